>>> design/ring_record_log_addresser_macros.svh
// Assertion macros for the ring record log addresser.
// Included by the top level; no other dependencies.
`ifndef RING_RECORD_LOG_ADDRESSER_MACROS_SVH
`define RING_RECORD_LOG_ADDRESSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define RRA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ring record log addresser: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RRA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ring record log addresser: next-cycle check failed");

`else

`define RRA_ASSERT_SAME(label, ante, cons)
`define RRA_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> design/rra_pkg.sv
// Shared types and constants for the ring record log addresser.
// No dependencies; used by every module of the block.
package rra_pkg;

   // Field widths.
   localparam int CNT_W  = 11;
   localparam int LEN_W  = 10;
   localparam int OFS_W  = 20;
   localparam int BUF_W  = 20;
   localparam int PROD_W = CNT_W + LEN_W;
   localparam int SUM_W  = CNT_W + 1;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;

   // Ring limits; the field widths above are sized for them.
   localparam int unsigned MAX_SLOTS        = 1024;
   localparam int unsigned MAX_RECORD_BYTES = 512;

   // Configuration port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_SLOT_COUNT   = 1'b0;
   localparam logic REG_RECORD_BYTES = 1'b1;
   localparam logic [CNT_W-1:0] SLOT_COUNT_RST   = 11'd1024;
   localparam logic [LEN_W-1:0] RECORD_BYTES_RST = 10'd512;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESET  = 2'd2;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_SIZE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_BUF_LOW  = 2'd2;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_ADVANCE,
      OP_MUL_IDX,
      OP_MUL_NUM,
      OP_CLIP,
      OP_START,
      OP_SPLIT
   } dp_op_type;

   // Result register loads.
   typedef enum logic [2:0] {
      EM_NONE,
      EM_ZERO,
      EM_SIZE,
      EM_BUF,
      EM_APPEND,
      EM_SEG1,
      EM_SEG2
   } emit_type;

   typedef struct packed {
      dp_op_type op;
      emit_type  emit;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic size_ok;
      logic buf_small;
      logic rd_empty;
      logic two_seg;
   } dp_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RST_OUT,
      ST_APP_CHK,
      ST_SIZE_ERR,
      ST_APP_MUL,
      ST_APP_OUT,
      ST_RD_MUL,
      ST_RD_CHK,
      ST_BUF_ERR,
      ST_RD_EMPTY,
      ST_RD_START,
      ST_RD_SPLIT,
      ST_SEG1,
      ST_SEG2
   } ctrl_state_type;

endpackage

>>> design/rra_csr.sv
// Configuration registers (slot count, record length) behind an APB-style port.
// Depends on rra_pkg.
module rra_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rra_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [rra_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [rra_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready,
   output logic [rra_pkg::CNT_W-1:0]      slot_count,
   output logic [rra_pkg::LEN_W-1:0]      record_bytes
);
   import rra_pkg::*;

   logic [CNT_W-1:0] slot_count_ff, slot_count_in;
   logic [LEN_W-1:0] record_bytes_ff, record_bytes_in;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   // Write decode.
   always_comb begin
      slot_count_in   = slot_count_ff;
      record_bytes_in = record_bytes_ff;
      if (wr_en) begin
         unique case (reg_sel)
            REG_SLOT_COUNT:   slot_count_in   = csr_pwdata[CNT_W-1:0];
            REG_RECORD_BYTES: record_bytes_in = csr_pwdata[LEN_W-1:0];
            default:          slot_count_in   = slot_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff   <= SLOT_COUNT_RST;
         record_bytes_ff <= RECORD_BYTES_RST;
      end else begin
         slot_count_ff   <= slot_count_in;
         record_bytes_ff <= record_bytes_in;
      end
   end

   // Read mux.
   always_comb begin
      unique case (reg_sel)
         REG_SLOT_COUNT:   csr_prdata = {{(CSR_DW-CNT_W){1'b0}}, slot_count_ff};
         REG_RECORD_BYTES: csr_prdata = {{(CSR_DW-LEN_W){1'b0}}, record_bytes_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign slot_count   = slot_count_ff;
   assign record_bytes = record_bytes_ff;

endmodule

>>> design/rra_ctrl.sv
// Sequencing state machine for the ring record log addresser.
// Depends on rra_pkg; drives datapath commands and the request stall.
module rra_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [rra_pkg::KIND_W-1:0]    req_kind,
   output logic                          req_stall,
   input  rra_pkg::dp_stat_type          stat,
   output rra_pkg::dp_cmd_type           cmd
);
   import rra_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  KIND_APPEND: state_in = ST_APP_CHK;
                  KIND_READ:   state_in = ST_RD_MUL;
                  KIND_RESET:  state_in = ST_RST_OUT;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_RST_OUT:  if (stat.out_free) state_in = ST_IDLE;
         ST_APP_CHK:  state_in = stat.size_ok ? ST_APP_MUL : ST_SIZE_ERR;
         ST_SIZE_ERR: if (stat.out_free) state_in = ST_IDLE;
         ST_APP_MUL:  state_in = ST_APP_OUT;
         ST_APP_OUT:  if (stat.out_free) state_in = ST_IDLE;
         ST_RD_MUL:   state_in = ST_RD_CHK;
         ST_RD_CHK: begin
            if (stat.buf_small)     state_in = ST_BUF_ERR;
            else if (stat.rd_empty) state_in = ST_RD_EMPTY;
            else                    state_in = ST_RD_START;
         end
         ST_BUF_ERR:  if (stat.out_free) state_in = ST_IDLE;
         ST_RD_EMPTY: if (stat.out_free) state_in = ST_IDLE;
         ST_RD_START: state_in = ST_RD_SPLIT;
         ST_RD_SPLIT: state_in = ST_SEG1;
         ST_SEG1: begin
            if (stat.out_free) state_in = stat.two_seg ? ST_SEG2 : ST_IDLE;
         end
         ST_SEG2:     if (stat.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.emit  = EM_NONE;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:     if (req_valid) cmd.op = OP_LOAD;
         ST_RST_OUT: begin
            if (stat.out_free) begin
               cmd.op   = OP_CLEAR;
               cmd.emit = EM_ZERO;
            end
         end
         ST_APP_CHK:  if (stat.size_ok) cmd.op = OP_ADVANCE;
         ST_SIZE_ERR: if (stat.out_free) cmd.emit = EM_SIZE;
         ST_APP_MUL:  cmd.op = OP_MUL_IDX;
         ST_APP_OUT:  if (stat.out_free) cmd.emit = EM_APPEND;
         ST_RD_MUL:   cmd.op = OP_MUL_NUM;
         ST_RD_CHK:   if (!stat.buf_small && !stat.rd_empty) cmd.op = OP_CLIP;
         ST_BUF_ERR:  if (stat.out_free) cmd.emit = EM_BUF;
         ST_RD_EMPTY: if (stat.out_free) cmd.emit = EM_ZERO;
         ST_RD_START: cmd.op = OP_START;
         ST_RD_SPLIT: cmd.op = OP_SPLIT;
         ST_SEG1:     if (stat.out_free) cmd.emit = EM_SEG1;
         ST_SEG2:     if (stat.out_free) cmd.emit = EM_SEG2;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

>>> design/rra_dp.sv
// Datapath: request latch, ring index and count, shared multiplier, window
// arithmetic and the result register. Depends on rra_pkg.
module rra_dp #(
   parameter int unsigned DATA_BASE = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rra_pkg::dp_cmd_type           cmd,
   output rra_pkg::dp_stat_type          stat,
   input  logic [rra_pkg::CNT_W-1:0]     slot_count,
   input  logic [rra_pkg::LEN_W-1:0]     record_bytes,
   input  logic [rra_pkg::LEN_W-1:0]     req_append_size,
   input  logic [rra_pkg::CNT_W-1:0]     req_newest_offset,
   input  logic [rra_pkg::CNT_W-1:0]     req_want_records,
   input  logic [rra_pkg::BUF_W-1:0]     req_buffer_bytes,
   input  logic                          req_read_order,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rra_pkg::OFS_W-1:0]     rsp_seg_offset,
   output logic [rra_pkg::CNT_W-1:0]     rsp_seg_records,
   output logic [rra_pkg::CNT_W-1:0]     rsp_total_records,
   output logic                          rsp_is_write,
   output logic [rra_pkg::STAT_W-1:0]    rsp_status,
   output logic                          rsp_last
);
   import rra_pkg::*;

   // Latched request and effective configuration.
   logic [LEN_W-1:0]  size_ff, size_in;
   logic [CNT_W-1:0]  offs_ff, offs_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [BUF_W-1:0]  buf_ff, buf_in;
   logic              order_ff, order_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   // Ring state.
   logic [CNT_W-1:0]  newest_ff, newest_in;
   logic [CNT_W-1:0]  stored_ff, stored_in;
   // Working registers.
   logic [CNT_W-1:0]  c_ff, c_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  first_ff, first_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   // Result register.
   logic              out_valid_ff, out_valid_in;
   logic [OFS_W-1:0]  out_ofs_ff, out_ofs_in;
   logic [CNT_W-1:0]  out_seg_ff, out_seg_in;
   logic [CNT_W-1:0]  out_tot_ff, out_tot_in;
   logic              out_wr_ff, out_wr_in;
   logic [STAT_W-1:0] out_st_ff, out_st_in;
   logic              out_last_ff, out_last_in;

   logic [CNT_W-1:0]  n_eff;
   logic [LEN_W-1:0]  len_eff;
   logic [CNT_W-1:0]  mul_a;
   logic [CNT_W-1:0]  stored_adv;
   logic [SUM_W-1:0]  offs_num;
   logic [SUM_W-1:0]  win_last;
   logic [SUM_W-1:0]  fwd_pos;
   logic [SUM_W-1:0]  fwd_lim;
   logic [SUM_W-1:0]  start_sum;
   logic [OFS_W-1:0]  slot_ofs;
   logic              two_seg;

   // Clamp the configuration into its usable range.
   always_comb begin
      n_eff   = (slot_count == '0) ? CNT_W'(1) : slot_count;
      len_eff = (record_bytes == '0) ? LEN_W'(1) : record_bytes;
      if (32'(n_eff) > MAX_SLOTS) n_eff = CNT_W'(MAX_SLOTS);
      if (32'(len_eff) > MAX_RECORD_BYTES) len_eff = LEN_W'(MAX_RECORD_BYTES);
   end

   // Shared multiplier; the operand depends on the step.
   always_comb begin
      case (cmd.op)
         OP_MUL_IDX: mul_a = newest_ff;
         OP_MUL_NUM: mul_a = num_ff;
         OP_SPLIT:   mul_a = start_ff;
         default:    mul_a = '0;
      endcase
   end

   // Window arithmetic terms.
   assign stored_adv = (stored_ff < n_ff) ? stored_ff + CNT_W'(1) : stored_ff;
   assign offs_num   = {1'b0, offs_ff} + {1'b0, num_ff};
   assign win_last   = offs_num - SUM_W'(1);
   assign fwd_pos    = {1'b0, idx_ff} + {1'b0, offs_ff} + SUM_W'(1);
   assign fwd_lim    = {1'b0, c_ff} - {1'b0, offs_ff} - SUM_W'(1);
   assign start_sum  = {1'b0, start_ff} + {1'b0, num_ff};
   assign two_seg    = first_ff < num_ff;
   assign slot_ofs   = OFS_W'(DATA_BASE) + prod_ff[OFS_W-1:0];

   // Datapath register updates per operation.
   always_comb begin
      size_in   = size_ff;
      offs_in   = offs_ff;
      num_in    = num_ff;
      buf_in    = buf_ff;
      order_in  = order_ff;
      n_in      = n_ff;
      len_in    = len_ff;
      newest_in = newest_ff;
      stored_in = stored_ff;
      c_in      = c_ff;
      idx_in    = idx_ff;
      start_in  = start_ff;
      first_in  = first_ff;
      prod_in   = prod_ff;
      case (cmd.op) inside
         OP_LOAD: begin
            size_in  = req_append_size;
            offs_in  = req_newest_offset;
            num_in   = req_want_records;
            buf_in   = req_buffer_bytes;
            order_in = req_read_order;
            n_in     = n_eff;
            len_in   = len_eff;
         end
         OP_CLEAR: begin
            newest_in = '0;
            stored_in = '0;
         end
         OP_ADVANCE: begin
            stored_in = stored_adv;
            if (stored_adv == CNT_W'(1) || newest_ff >= n_ff - CNT_W'(1)) begin
               newest_in = '0;
            end else begin
               newest_in = newest_ff + CNT_W'(1);
            end
         end
         OP_MUL_IDX, OP_MUL_NUM: begin
            prod_in = {{LEN_W{1'b0}}, mul_a} * {{CNT_W{1'b0}}, len_ff};
            c_in    = (stored_ff < n_ff) ? stored_ff : n_ff;
         end
         OP_CLIP: begin
            if (offs_num > {1'b0, c_ff}) num_in = c_ff - offs_ff;
            idx_in = (newest_ff < n_ff) ? newest_ff : n_ff - CNT_W'(1);
         end
         OP_START: begin
            if (!order_ff) begin
               if ({1'b0, idx_ff} < fwd_lim) start_in = fwd_pos[CNT_W-1:0];
               else start_in = fwd_pos[CNT_W-1:0] - c_ff;
            end else begin
               if ({1'b0, idx_ff} < win_last) begin
                  start_in = c_ff + idx_ff - win_last[CNT_W-1:0];
               end else begin
                  start_in = idx_ff - win_last[CNT_W-1:0];
               end
            end
         end
         OP_SPLIT: begin
            prod_in  = {{LEN_W{1'b0}}, mul_a} * {{CNT_W{1'b0}}, len_ff};
            first_in = (start_sum >= {1'b0, n_ff}) ? n_ff - start_ff : num_ff;
         end
         default: prod_in = prod_ff;
      endcase
   end

   // Result register load.
   always_comb begin
      out_valid_in = out_valid_ff & rsp_stall;
      out_ofs_in   = out_ofs_ff;
      out_seg_in   = out_seg_ff;
      out_tot_in   = out_tot_ff;
      out_wr_in    = out_wr_ff;
      out_st_in    = out_st_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit != EM_NONE) begin
         out_valid_in = 1'b1;
         out_ofs_in   = '0;
         out_seg_in   = '0;
         out_tot_in   = '0;
         out_wr_in    = 1'b0;
         out_st_in    = STAT_OK;
         out_last_in  = 1'b1;
         case (cmd.emit)
            EM_SIZE: out_st_in = STAT_BAD_SIZE;
            EM_BUF:  out_st_in = STAT_BUF_LOW;
            EM_APPEND: begin
               out_ofs_in = slot_ofs;
               out_seg_in = CNT_W'(1);
               out_wr_in  = 1'b1;
            end
            EM_SEG1: begin
               out_ofs_in  = slot_ofs;
               out_seg_in  = two_seg ? first_ff : num_ff;
               out_tot_in  = num_ff;
               out_last_in = !two_seg;
            end
            EM_SEG2: begin
               out_ofs_in = OFS_W'(DATA_BASE);
               out_seg_in = num_ff - first_ff;
               out_tot_in = num_ff;
            end
            default: out_st_in = STAT_OK;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         newest_ff    <= '0;
         stored_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         newest_ff    <= newest_in;
         stored_ff    <= stored_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      size_ff     <= size_in;
      offs_ff     <= offs_in;
      num_ff      <= num_in;
      buf_ff      <= buf_in;
      order_ff    <= order_in;
      n_ff        <= n_in;
      len_ff      <= len_in;
      c_ff        <= c_in;
      idx_ff      <= idx_in;
      start_ff    <= start_in;
      first_ff    <= first_in;
      prod_ff     <= prod_in;
      out_ofs_ff  <= out_ofs_in;
      out_seg_ff  <= out_seg_in;
      out_tot_ff  <= out_tot_in;
      out_wr_ff   <= out_wr_in;
      out_st_ff   <= out_st_in;
      out_last_ff <= out_last_in;
   end

   // Status toward the controller.
   assign stat.out_free  = !out_valid_ff || !rsp_stall;
   assign stat.size_ok   = (size_ff == len_ff);
   assign stat.buf_small = ({1'b0, buf_ff} < prod_ff);
   assign stat.rd_empty  = (c_ff == '0) || (offs_ff >= c_ff) || (num_ff == '0);
   assign stat.two_seg   = two_seg;

   assign rsp_valid         = out_valid_ff;
   assign rsp_seg_offset    = out_ofs_ff;
   assign rsp_seg_records   = out_seg_ff;
   assign rsp_total_records = out_tot_ff;
   assign rsp_is_write      = out_wr_ff;
   assign rsp_status        = out_st_ff;
   assign rsp_last          = out_last_ff;

endmodule

>>> design/ring_record_log_addresser.sv
// Ring record log addresser: one request at a time; no new request is taken
// until the controller is back in idle. Reset, size error, append, buffer error,
// empty read and read (with a second wrap segment after the first) each end in
// the result register; an unused kind is dropped. The controller walks the
// single shared multiplier step by step, and result stalls hold it in place.
// Synchronous reset empties the log and restores slot_count 1024, record_bytes 512.
module ring_record_log_addresser #(
   parameter int unsigned DATA_BASE = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rra_pkg::KIND_W-1:0]    req_kind,
   input  logic [rra_pkg::LEN_W-1:0]     req_append_size,
   input  logic [rra_pkg::CNT_W-1:0]     req_newest_offset,
   input  logic [rra_pkg::CNT_W-1:0]     req_want_records,
   input  logic [rra_pkg::BUF_W-1:0]     req_buffer_bytes,
   input  logic                          req_read_order,
   // Result channel.
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rra_pkg::OFS_W-1:0]     rsp_seg_offset,
   output logic [rra_pkg::CNT_W-1:0]     rsp_seg_records,
   output logic [rra_pkg::CNT_W-1:0]     rsp_total_records,
   output logic                          rsp_is_write,
   output logic [rra_pkg::STAT_W-1:0]    rsp_status,
   output logic                          rsp_last,
   // Configuration port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rra_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [rra_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [rra_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import rra_pkg::*;

`include "ring_record_log_addresser_macros.svh"

   logic [CNT_W-1:0] slot_count;
   logic [LEN_W-1:0] record_bytes;
   dp_cmd_type       cmd;
   dp_stat_type      stat;
   logic             req_known;
   logic             append_shape_ok;
   logic             split_shape_ok;

   rra_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .slot_count   (slot_count),
      .record_bytes (record_bytes)
   );

   rra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rra_dp #(
      .DATA_BASE (DATA_BASE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .slot_count        (slot_count),
      .record_bytes      (record_bytes),
      .req_append_size   (req_append_size),
      .req_newest_offset (req_newest_offset),
      .req_want_records  (req_want_records),
      .req_buffer_bytes  (req_buffer_bytes),
      .req_read_order    (req_read_order),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_seg_offset    (rsp_seg_offset),
      .rsp_seg_records   (rsp_seg_records),
      .rsp_total_records (rsp_total_records),
      .rsp_is_write      (rsp_is_write),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // Terms used by the checks below.
   assign req_known = (req_kind == KIND_APPEND) || (req_kind == KIND_READ)
                      || (req_kind == KIND_RESET);
   assign append_shape_ok = (rsp_seg_records == CNT_W'(1)) && rsp_last
                            && (rsp_status == STAT_OK);
   assign split_shape_ok = (rsp_status == STAT_OK) && !rsp_is_write
                           && (rsp_total_records > rsp_seg_records);

   // A request of a known kind makes the controller busy in the cycle after it is taken.
   `RRA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall && req_known, req_stall)

   // An append write always covers one record, ends its request and is good.
   `RRA_ASSERT_SAME(a_append_shape, rsp_valid && rsp_is_write, append_shape_ok)

   // A first wrap segment only comes from a successful, nonempty read.
   `RRA_ASSERT_SAME(a_split_read, rsp_valid && !rsp_last, split_shape_ok)

   // The datapath never loads a result while the held one is stalled.
   `RRA_ASSERT_SAME(a_no_overwrite, cmd.emit != EM_NONE, !rsp_valid || !rsp_stall)

endmodule
